/* src/pidsd_pkg.sv */
package pidsd_pkg;

    localparam int HIST_DEPTH = 8;
    localparam int HIST_IDX_W = $clog2(HIST_DEPTH);
    localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
    localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;

    localparam logic [2:0] REG_TARGET = 3'd0;
    localparam logic [2:0] REG_GAIN_P = 3'd1;
    localparam logic [2:0] REG_GAIN_I = 3'd2;
    localparam logic [2:0] REG_GAIN_D = 3'd3;
    localparam logic [2:0] REG_LIMIT  = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_DT0  = 2'd2;

    localparam int DIV_STEPS = 48;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    typedef struct packed {
        logic load;       // capture input, form error
        logic integ;      // integral update
        logic div_start;  // set up divide
        logic div_step;   // one quotient bit
        logic deriv;      // derivative + history + steady
        logic mul_p;
        logic mul_i;
        logic mul_d;
        logic finish;     // drive saturation, result register
    } pidsd_cmd_t;

    typedef struct packed {
        logic div_done;
    } pidsd_sts_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sh0_7fff_ffff) return S32_MAX;
        else if (v < -66'sh0_8000_0000) return S32_MIN;
        else return v[31:0];
    endfunction

    function automatic logic ovf32(input logic signed [65:0] v);
        return (v > 66'sh0_7fff_ffff) || (v < -66'sh0_8000_0000);
    endfunction

endpackage

/* src/pid_with_steady_state_detect_top.sv */
// Steps: load, integ, divide setup, 48 divide steps, deriv, mul P/I/D, finish.
// One word in flight at a time; finish waits until the output register is free.
// A new word is accepted while a previous result waits in the output register.
// Reset (rst_n low, async): config, integ, outputs zero; history 1.0, steady clear.
module pid_with_steady_state_detect_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] measured, [63:32] time_step
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] drive, [32] steady, [34:33] status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    pidsd_pkg::pidsd_cmd_t cmd;
    pidsd_pkg::pidsd_sts_t sts;
    logic busy, in_fire, out_free, ovalid_reg, cfg_fire;
    logic signed [31:0] drive;
    logic steady;
    logic [1:0] status;

    assign s_axis_tready = !busy;
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign out_free = !ovalid_reg || m_axis_tready;
    assign cfg_ready = !busy;
    assign cfg_fire = cfg_valid && cfg_ready;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata = {5'd0, status, steady, drive};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (cmd.finish)
            ovalid_reg <= 1'b1;
        else if (m_axis_tready)
            ovalid_reg <= 1'b0;
    end

    pidsd_ctrl u_ctrl
    (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_free(out_free),
        .sts(sts), .busy(busy), .cmd(cmd)
    );

    pidsd_dp u_dp
    (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .cfg_fire(cfg_fire), .cfg_index(cfg_index), .cfg_value(cfg_data),
        .measured(s_axis_tdata[31:0]), .time_step(s_axis_tdata[63:32]),
        .drive(drive), .steady(steady), .status(status)
    );

endmodule

/* src/pidsd_ctrl.sv */
module pidsd_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_fire,
    input  logic                   out_free,
    input  pidsd_pkg::pidsd_sts_t  sts,
    output logic                   busy,
    output pidsd_pkg::pidsd_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_INTEG = 4'd1;
    localparam logic [3:0] S_DIVS  = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_DER   = 4'd4;
    localparam logic [3:0] S_MP    = 4'd5;
    localparam logic [3:0] S_MI    = 4'd6;
    localparam logic [3:0] S_MD    = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    state_next = S_INTEG;
                end
            end
            S_INTEG:
            begin
                cmd.integ = 1'b1;
                state_next = S_DIVS;
            end
            S_DIVS:
            begin
                cmd.div_start = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (sts.div_done)
                    state_next = S_DER;
                else
                    cmd.div_step = 1'b1;
            end
            S_DER:
            begin
                cmd.deriv = 1'b1;
                state_next = S_MP;
            end
            S_MP:
            begin
                cmd.mul_p = 1'b1;
                state_next = S_MI;
            end
            S_MI:
            begin
                cmd.mul_i = 1'b1;
                state_next = S_MD;
            end
            S_MD:
            begin
                cmd.mul_d = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == S_IDLE)
        else $error("load outside idle");
    a_fin_next_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> state_reg == S_IDLE)
        else $error("finish not followed by idle");
    a_div_enter: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> state_reg == S_DIV)
        else $error("divide not entered");

endmodule

/* src/pidsd_dp.sv */
module pidsd_dp
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  pidsd_pkg::pidsd_cmd_t         cmd,
    output pidsd_pkg::pidsd_sts_t         sts,
    input  logic                          cfg_fire,
    input  logic [2:0]                    cfg_index,
    input  logic [31:0]                   cfg_value,
    input  logic signed [31:0]            measured,
    input  logic [31:0]                   time_step,
    output logic signed [31:0]            drive,
    output logic                          steady,
    output logic [1:0]                    status
);

    logic signed [31:0] target_reg, gp_reg, gi_reg, gd_reg;
    logic [30:0]        limit_reg;
    logic signed [31:0] integ_reg, deriv_reg;
    logic signed [31:0] hist_reg [pidsd_pkg::HIST_DEPTH];
    logic               steady_reg;

    logic signed [31:0] err_reg;
    logic [31:0]        dt_reg;
    logic               sat_reg, dt0_reg;

    logic [47:0]        dvd_reg, quo_reg;
    logic [32:0]        rem_reg;
    logic               neg_reg;
    logic [pidsd_pkg::DIV_CNT_W-1:0] cnt_reg;

    logic signed [65:0] acc_reg;

    logic signed [32:0] err_full;
    logic signed [63:0] prod;
    logic signed [65:0] integ_sum;
    logic signed [32:0] diff;
    logic [32:0]        diff_mag;
    logic [32:0]        rem_sh;
    logic signed [65:0] dq;
    logic               all_in;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    logic signed [65:0] acc_new;

    assign err_full = 33'(target_reg) - 33'(measured);
    assign prod = mul_a * mul_b;
    // full err*dt = err*dt[30:0] + (err<<31 if dt[31])
    assign integ_sum = 66'(integ_reg)
        + 66'((prod + (dt_reg[31] ? mul_p : 64'sd0)) >>> 16);
    assign diff = 33'(err_reg) - 33'(hist_reg[0]);
    assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
    assign rem_sh = {rem_reg[31:0], dvd_reg[47]};
    assign dq = neg_reg ? -66'(quo_reg) : 66'(quo_reg);
    assign acc_new = acc_reg + 66'(prod >>> 16);
    assign sts.div_done = (cnt_reg == '0);

    always_comb
    begin
        mul_a = err_reg;
        mul_b = $signed({1'b0, dt_reg[30:0]});
        if (cmd.mul_p)
        begin
            mul_a = gp_reg;
            mul_b = err_reg;
        end
        else if (cmd.mul_i)
        begin
            mul_a = gi_reg;
            mul_b = integ_reg;
        end
        else if (cmd.mul_d)
        begin
            mul_a = gd_reg;
            mul_b = deriv_reg;
        end
    end

    // err * unsigned dt: split off dt bit 31 as err<<31
    assign mul_p = 64'(err_reg) <<< 31;

    always_comb
    begin
        all_in = 1'b1;
        for (int i = 0; i < pidsd_pkg::HIST_DEPTH; i++)
        begin
            logic signed [31:0] e;
            logic [32:0] m;
            e = (i == 0) ? err_reg : hist_reg[i-1];
            m = e[31] ? 33'(-33'(e)) : 33'(e);
            if (m > 33'(limit_reg))
                all_in = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            gp_reg <= '0;
            gi_reg <= '0;
            gd_reg <= '0;
            limit_reg <= '0;
            integ_reg <= '0;
            deriv_reg <= '0;
            steady_reg <= 1'b0;
            sat_reg <= 1'b0;
            for (int i = 0; i < pidsd_pkg::HIST_DEPTH; i++)
                hist_reg[i] <= pidsd_pkg::ONE_Q16;
            cnt_reg <= '0;
            drive <= '0;
            steady <= 1'b0;
            status <= pidsd_pkg::ST_OK;
        end
        else
        begin
            if (cfg_fire)
            begin
                case (cfg_index)
                    pidsd_pkg::REG_TARGET:
                    begin
                        target_reg <= cfg_value;
                        steady_reg <= 1'b0;
                        for (int i = 0; i < pidsd_pkg::HIST_DEPTH; i++)
                            hist_reg[i] <= pidsd_pkg::ONE_Q16;
                    end
                    pidsd_pkg::REG_GAIN_P: gp_reg <= cfg_value;
                    pidsd_pkg::REG_GAIN_I: gi_reg <= cfg_value;
                    pidsd_pkg::REG_GAIN_D: gd_reg <= cfg_value;
                    pidsd_pkg::REG_LIMIT:  limit_reg <= cfg_value[30:0];
                    default: ;
                endcase
            end
            if (cmd.load)
                sat_reg <= pidsd_pkg::ovf32(66'(err_full));
            if (cmd.integ)
            begin
                integ_reg <= pidsd_pkg::sat32(integ_sum);
                if (pidsd_pkg::ovf32(integ_sum))
                    sat_reg <= 1'b1;
            end
            if (cmd.div_start)
                cnt_reg <= pidsd_pkg::DIV_CNT_W'(pidsd_pkg::DIV_STEPS);
            else if (cmd.div_step)
                cnt_reg <= cnt_reg - pidsd_pkg::DIV_CNT_W'(1);
            if (cmd.deriv)
            begin
                if (!dt0_reg)
                begin
                    deriv_reg <= pidsd_pkg::sat32(dq);
                    if (pidsd_pkg::ovf32(dq))
                        sat_reg <= 1'b1;
                end
                hist_reg[0] <= err_reg;
                for (int i = 1; i < pidsd_pkg::HIST_DEPTH; i++)
                    hist_reg[i] <= hist_reg[i-1];
                if (all_in)
                    steady_reg <= 1'b1;
            end
            if (cmd.finish)
            begin
                drive <= pidsd_pkg::sat32(acc_reg);
                steady <= steady_reg;
                status <= dt0_reg ? pidsd_pkg::ST_DT0
                        : ((sat_reg || pidsd_pkg::ovf32(acc_reg))
                           ? pidsd_pkg::ST_SAT : pidsd_pkg::ST_OK);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            err_reg <= pidsd_pkg::sat32(66'(err_full));
            dt_reg <= time_step;
            dt0_reg <= (time_step == '0);
            acc_reg <= '0;
        end
        if (cmd.div_start)
        begin
            dvd_reg <= {diff_mag[31:0], 16'd0};
            neg_reg <= diff[32];
            rem_reg <= {32'd0, diff_mag[32]};
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_sh >= 33'(dt_reg))
            begin
                rem_reg <= rem_sh - 33'(dt_reg);
                quo_reg <= {quo_reg[46:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[46:0], 1'b0};
            end
            dvd_reg <= {dvd_reg[46:0], 1'b0};
        end
        if (cmd.mul_p || cmd.mul_i || cmd.mul_d)
            acc_reg <= acc_new;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= pidsd_pkg::DIV_CNT_W'(pidsd_pkg::DIV_STEPS))
        else $error("divide count out of range");
    a_cfg_target: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_fire && cfg_index == pidsd_pkg::REG_TARGET |=> !steady_reg)
        else $error("setpoint write did not clear steady");
    a_steady_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(steady_reg) && !$past(cfg_fire) |-> steady_reg)
        else $error("steady flag dropped");

endmodule

/* tb/pid_with_steady_state_detect_checker.sv */
module pid_with_steady_state_detect_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]         status;
        logic               steady;
        logic signed [31:0] drive;
    } pid_word_t;

    logic signed [63:0] setpoint, kp, ki, kd;
    logic [63:0]        limit;
    logic signed [63:0] integ, deriv;
    logic signed [63:0] hist [pidsd_pkg::HIST_DEPTH];
    logic               steady_flag;
    pid_word_t          drive_q[$];

    function automatic logic signed [63:0] sat64(input logic signed [63:0] v, ref logic sat);
        if (v > 64'sd2147483647) begin sat = 1; return 64'sd2147483647; end
        if (v < -64'sd2147483648) begin sat = 1; return -64'sd2147483648; end
        return v;
    endfunction

    function automatic logic signed [63:0] floor_q16(input logic signed [63:0] v);
        return v >>> 16;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    task automatic predict_drive(input logic [63:0] word);
        logic signed [63:0] meas, err, diff, acc;
        logic [63:0] dt, mag, q;
        logic sat;
        logic all_in;
        pid_word_t r;
        sat = 0;
        meas = $signed(word[31:0]);
        dt = {32'd0, word[63:32]};
        err = sat64(setpoint - meas, sat);
        integ = sat64(integ + floor_q16(err * $signed(dt)), sat);
        if (dt != 0)
        begin
            diff = err - hist[0];
            mag = diff < 0 ? -diff : diff;
            q = (mag << 16) / dt;
            deriv = sat64(diff < 0 ? -$signed(q) : $signed(q), sat);
        end
        for (int i = pidsd_pkg::HIST_DEPTH - 1; i > 0; i--)
            hist[i] = hist[i-1];
        hist[0] = err;
        all_in = 1;
        for (int i = 0; i < pidsd_pkg::HIST_DEPTH; i++)
            if ((hist[i] < 0 ? -hist[i] : hist[i]) > $signed(limit))
                all_in = 0;
        if (all_in)
            steady_flag = 1;
        acc = floor_q16(kp * err) + floor_q16(ki * integ) + floor_q16(kd * deriv);
        r.drive = 32'(sat64(acc, sat));
        r.steady = steady_flag;
        r.status = dt == 0 ? pidsd_pkg::ST_DT0
                 : (sat ? pidsd_pkg::ST_SAT : pidsd_pkg::ST_OK);
        drive_q.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pid_word_t got, want;
        if (!rst_n)
        begin
            setpoint = 0; kp = 0; ki = 0; kd = 0; limit = 0;
            integ = 0; deriv = 0; steady_flag = 0;
            for (int i = 0; i < pidsd_pkg::HIST_DEPTH; i++)
                hist[i] = pidsd_pkg::ONE_Q16;
            drive_q.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[34:0];
                if (drive_q.size() == 0)
                    report_mismatch("unexpected word", 64'(m_axis_tdata), 64'd0);
                else
                begin
                    want = drive_q.pop_front();
                    if (got.drive !== want.drive)
                        report_mismatch("drive", 64'(got.drive), 64'(want.drive));
                    if (got.steady !== want.steady)
                        report_mismatch("steady", 64'(got.steady), 64'(want.steady));
                    if (got.status !== want.status)
                        report_mismatch("status", 64'(got.status), 64'(want.status));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    pidsd_pkg::REG_TARGET:
                    begin
                        setpoint = $signed(cfg_data);
                        for (int i = 0; i < pidsd_pkg::HIST_DEPTH; i++)
                            hist[i] = pidsd_pkg::ONE_Q16;
                        steady_flag = 0;
                    end
                    pidsd_pkg::REG_GAIN_P: kp = $signed(cfg_data);
                    pidsd_pkg::REG_GAIN_I: ki = $signed(cfg_data);
                    pidsd_pkg::REG_GAIN_D: kd = $signed(cfg_data);
                    pidsd_pkg::REG_LIMIT:  limit = {33'd0, cfg_data[30:0]};
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_drive(s_axis_tdata);
            pending = drive_q.size();
        end
    end
endmodule

/* tb/pid_with_steady_state_detect_top_test.sv */
module pid_with_steady_state_detect_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk, rst_n;
    logic        s_axis_tvalid, s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid, m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        cfg_valid, cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    int          fail_count, pending;
    int          send_idle, recv_stall;

    pid_with_steady_state_detect_top DUT (.*);
    pid_with_steady_state_detect_checker u_checker (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("Verification failed");
        $finish;
    end

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall);

    task automatic drain;
        while (pending != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        drain();
        @(negedge clk);
        cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    task automatic send_word(input logic [31:0] meas, input logic [31:0] dt);
        @(negedge clk);
        while ($urandom_range(99) < send_idle) @(negedge clk);
        s_axis_tvalid <= 1; s_axis_tdata <= {dt, meas};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
        s_axis_tvalid <= 0;
    endtask

    function automatic logic [31:0] pick32();
        case ($urandom_range(5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(131072) - 65536;
            3: return $urandom_range(4095) - 2048;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_dt();
        case ($urandom_range(5))
            0: return 0;
            1: return 32'hffffffff;
            2: return $urandom_range(65536);
            default: return $urandom;
        endcase
    endfunction

    task automatic run_phase(input int n, input int idle, input int stall);
        logic [31:0] sp;
        send_idle = idle; recv_stall = stall;
        drain();
        sp = $urandom_range(3) == 0 ? pick32() : $urandom_range(65536) - 32768;
        write_reg(pidsd_pkg::REG_TARGET, sp);
        write_reg(pidsd_pkg::REG_GAIN_P, pick32());
        write_reg(pidsd_pkg::REG_GAIN_I, $urandom_range(1) ? pick32() : $urandom_range(256));
        write_reg(pidsd_pkg::REG_GAIN_D, pick32());
        write_reg(pidsd_pkg::REG_LIMIT, $urandom_range(1) ? $urandom_range(2048) : $urandom);
        write_reg(3'd6, $urandom);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(1))
                send_word(sp + $urandom_range(1024) - 512, $urandom_range(1) ? 65536 : pick_dt());
            else
                send_word(pick32(), pick_dt());
        end
    endtask

    initial
    begin
        rst_n = 0; s_axis_tvalid = 0; s_axis_tdata = 0;
        cfg_valid = 0; cfg_index = 0; cfg_data = 0; send_idle = 0; recv_stall = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        // directed: defaults, then extremes
        send_word(32'h0, 32'h0);
        send_word(32'h7fffffff, 32'hffffffff);
        write_reg(pidsd_pkg::REG_TARGET, 32'h7fffffff);
        write_reg(pidsd_pkg::REG_GAIN_P, 32'h7fffffff);
        write_reg(pidsd_pkg::REG_GAIN_I, 32'h80000000);
        write_reg(pidsd_pkg::REG_GAIN_D, 32'h7fffffff);
        write_reg(pidsd_pkg::REG_LIMIT, 32'h7fffffff);
        send_word(32'h80000000, 32'hffffffff);
        send_word(32'h80000000, 32'h1);
        send_word(32'h7fffffff, 32'h0);
        send_word(32'h0, 32'h1);
        drain();
        write_reg(pidsd_pkg::REG_TARGET, 32'h80000000);
        write_reg(pidsd_pkg::REG_GAIN_P, 32'h00010000);
        write_reg(pidsd_pkg::REG_GAIN_I, 32'h0);
        write_reg(pidsd_pkg::REG_GAIN_D, 32'h80000000);
        write_reg(pidsd_pkg::REG_LIMIT, 32'h0);
        send_word(32'h7fffffff, 32'h00010000);
        send_word(32'h80000000, 32'h00010000);
        for (int i = 0; i < 9; i++)
            send_word(32'h80000000, 32'h00010000);
        drain();
        write_reg(pidsd_pkg::REG_TARGET, 32'h0);
        write_reg(pidsd_pkg::REG_LIMIT, 32'h100);
        for (int i = 0; i < 9; i++)
            send_word(i, 32'h00008000);
        write_reg(3'd7, 32'hffffffff);
        for (int p = 0; p < 5; p++)
        begin
            run_phase(25, 0, 0);
            run_phase(25, 71, 0);
            run_phase(25, 0, 71);
            run_phase(25, 24, 24);
        end
        drain();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
